>>> hw/rtl/dfp_pkg.sv
// Shared types and constants of the display frame parser.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package dfp_pkg;

  localparam int unsigned DigitCount = 20;
  localparam int unsigned DigitW     = 5;
  localparam int unsigned ValueW     = 4;
  localparam int unsigned KindW      = 2;
  localparam int unsigned BoardW     = 2;

  localparam logic [7:0] HeaderByte    = 8'hF0;
  localparam logic [7:0] BroadcastByte = 8'hF1;
  localparam logic [7:0] AddrBase      = 8'd8;
  localparam logic [7:0] AddrLimit     = 8'd89;
  localparam logic [7:0] MaxDigitByte  = 8'd9;

  localparam logic [ValueW-1:0] BlankValue = 4'd10;

  // Width of the rebased address byte and of the board window bounds
  localparam int unsigned OffW = 8;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_ADDR   = 3'b010,
    PH_DATA   = 3'b100
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_ALL   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DigitW-1:0]  index;
    logic [ValueW-1:0]  value;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

endpackage

>>> hw/rtl/dfp_in_reg.sv
// Input register of the display frame parser: captures one received byte per transfer.
// Depends on dfp_pkg.
`timescale 1ns / 1ps

module dfp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              take_i,
  output dfp_pkg::in_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_o.valid   = valid_q;
  assign item_o.rx_byte = byte_q;

endmodule

>>> hw/rtl/dfp_parser.sv
// Frame decode of the display frame parser: parse phase, target and result register.
// Depends on dfp_pkg; fed by dfp_in_reg.
`timescale 1ns / 1ps

module dfp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dfp_pkg::BoardW-1:0]     cfg_board_i,
  input  dfp_pkg::in_item_t              item_i,
  output logic                           take_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output dfp_pkg::result_t               res_o
);

  localparam logic [dfp_pkg::OffW-1:0] DigitCountW = dfp_pkg::OffW'(dfp_pkg::DigitCount);

  logic [dfp_pkg::BoardW-1:0] board_q;
  dfp_pkg::phase_e            phase_q, phase_d;
  dfp_pkg::kind_e             tkind_q, tkind_d;
  logic [dfp_pkg::DigitW-1:0] tdigit_q, tdigit_d;
  logic                       rvalid_q, rvalid_d;
  dfp_pkg::result_t           res_q, res_d;

  logic [7:0]                 b;
  logic [dfp_pkg::OffW-1:0]   off;
  logic [dfp_pkg::OffW-1:0]   win_lo;
  logic [dfp_pkg::OffW-1:0]   win_hi;
  logic [dfp_pkg::OffW-1:0]   rel;
  logic                       board_hit;
  logic [dfp_pkg::ValueW-1:0] data_val;

  assign take_o = item_i.valid && (!rvalid_q || res_ready_i);
  assign b      = item_i.rx_byte;

  // Board window: board n owns rebased addresses n*DigitCount up to (n+1)*DigitCount-1
  assign off       = b - dfp_pkg::AddrBase;
  assign win_lo    = dfp_pkg::OffW'(board_q) * DigitCountW;
  assign win_hi    = win_lo + DigitCountW;
  assign rel       = off - win_lo;
  assign board_hit = (b >= dfp_pkg::AddrBase) && (b < dfp_pkg::AddrLimit)
                     && (off >= win_lo) && (off < win_hi);

  assign data_val = ((b == 8'd0) || (b > dfp_pkg::MaxDigitByte)) ? dfp_pkg::BlankValue
                                                                  : b[dfp_pkg::ValueW-1:0];

  always_comb begin
    phase_d     = phase_q;
    tkind_d     = tkind_q;
    tdigit_d    = tdigit_q;
    res_d       = res_q;
    rvalid_d    = rvalid_q;
    if (res_ready_i) begin
      rvalid_d = 1'b0;
    end
    if (take_o) begin
      rvalid_d    = 1'b1;
      res_d.kind  = dfp_pkg::KIND_NONE;
      res_d.index = '0;
      res_d.value = '0;
      unique case (phase_q)
        dfp_pkg::PH_ADDR: begin
          if (b == dfp_pkg::BroadcastByte) begin
            tkind_d  = dfp_pkg::KIND_ALL;
            tdigit_d = '0;
            phase_d  = dfp_pkg::PH_DATA;
          end else if (b < dfp_pkg::AddrBase) begin
            // Low addresses belong to board zero and address no digit
            if (board_q == '0) begin
              tkind_d  = dfp_pkg::KIND_NONE;
              tdigit_d = '0;
              phase_d  = dfp_pkg::PH_DATA;
            end else begin
              phase_d = dfp_pkg::PH_HEADER;
            end
          end else if (board_hit) begin
            tkind_d  = dfp_pkg::KIND_DIGIT;
            tdigit_d = rel[dfp_pkg::DigitW-1:0];
            phase_d  = dfp_pkg::PH_DATA;
          end else begin
            phase_d = dfp_pkg::PH_HEADER;
          end
        end
        dfp_pkg::PH_DATA: begin
          if (tkind_q == dfp_pkg::KIND_DIGIT) begin
            res_d.kind  = dfp_pkg::KIND_DIGIT;
            res_d.index = tdigit_q;
            res_d.value = data_val;
          end else if (tkind_q == dfp_pkg::KIND_ALL) begin
            res_d.kind  = dfp_pkg::KIND_ALL;
            res_d.value = dfp_pkg::BlankValue;
          end
          phase_d = dfp_pkg::PH_HEADER;
        end
        default: begin
          phase_d = (b == dfp_pkg::HeaderByte) ? dfp_pkg::PH_ADDR : dfp_pkg::PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q  <= '0;
      phase_q  <= dfp_pkg::PH_HEADER;
      tkind_q  <= dfp_pkg::KIND_NONE;
      tdigit_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        board_q <= cfg_board_i;
      end
      phase_q  <= phase_d;
      tkind_q  <= tkind_d;
      tdigit_q <= tdigit_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/display_frame_parser.sv
// Top level of the display frame parser: input register, frame decode, result register.
// Depends on dfp_pkg, dfp_in_reg and dfp_parser.
//
//   channel  direction  signals                        meaning
//   s_axis   in         tvalid tready tdata[7:0]       received byte
//   m_axis   out        tvalid tready tdata[15:0]      one update record per byte
//   cfg      in         cfg_valid_i cfg_ready_o data   board id
//
// One byte per cycle sustained while m_axis does not stall; a byte's result passes through
// the input register and then the result register before it is valid.
// Reset clears the parse phase, the target, the board id and both valid flags.
// A stall on m_axis holds the result register; once the input register is also full,
// s_axis_tready drops in the same cycle as the stall.
`timescale 1ns / 1ps

module display_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [1:0] update_kind, [6:2] digit_index,
                                                      // [10:7] digit_value, [15:11] zero
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dfp_pkg::BoardW-1:0]  cfg_data_i      // board_id
);

  dfp_pkg::in_item_t item;
  dfp_pkg::result_t  res;
  logic              take;

  assign cfg_ready_o = 1'b1;

  dfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .take_i     (take),
    .item_o     (item)
  );

  dfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_board_i (cfg_data_i),
    .item_i      (item),
    .take_o      (take),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.value, res.index, res.kind};

  // A free output side never stalls the input
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side was ready");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("undefined update kind");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == dfp_pkg::KIND_DIGIT) |->
      (m_axis_tdata[6:2] < dfp_pkg::DigitW'(dfp_pkg::DigitCount)) &&
      (m_axis_tdata[10:7] != 4'd0) && (m_axis_tdata[10:7] <= dfp_pkg::BlankValue))
    else $error("digit update out of range");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == dfp_pkg::KIND_NONE) |->
      (m_axis_tdata[10:2] == 9'd0))
    else $error("empty result carries data");

endmodule
